/* sv/hdwa_pkg.sv */
// ----------------------------------------------------------------------------
// hdwa_pkg
// Shared types, character codes and the hex digit decoder of the hex-dump
// word assembler.
// ----------------------------------------------------------------------------
package hdwa_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned NibbleWidth = 4;
  localparam int unsigned ByteWidth   = 8;

  // ASCII codes the parser reacts to
  localparam logic [CharWidth-1:0] ChNewline = 8'h0A;
  localparam logic [CharWidth-1:0] ChSpace   = 8'h20;
  localparam logic [CharWidth-1:0] ChZero    = 8'h30;
  localparam logic [CharWidth-1:0] ChNine    = 8'h39;
  localparam logic [CharWidth-1:0] ChUpperA  = 8'h41;
  localparam logic [CharWidth-1:0] ChUpperF  = 8'h46;
  localparam logic [CharWidth-1:0] ChLowerA  = 8'h61;
  localparam logic [CharWidth-1:0] ChLowerF  = 8'h66;
  localparam logic [NibbleWidth-1:0] DigitTen = 4'd10;

  // last byte slot of a word; the byte that lands there completes it
  localparam logic [1:0] LastByte = 2'd3;

  // decoded hex digit
  typedef struct packed {
    logic                   ok;
    logic [NibbleWidth-1:0] value;
  } hex_digit_t;

  // what the parser hands back for one item
  typedef struct packed {
    logic                 emit;
    logic [WordWidth-1:0] word;
  } parse_result_t;

  function automatic hex_digit_t hex_decode(input logic [CharWidth-1:0] c);
    hex_digit_t d;
    logic [CharWidth-1:0] diff;
    d.ok    = 1'b0;
    d.value = '0;
    diff    = '0;
    priority if (c >= ChZero && c <= ChNine) begin
      diff    = c - ChZero;
      d.ok    = 1'b1;
      d.value = diff[NibbleWidth-1:0];
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      diff    = c - ChLowerA;
      d.ok    = 1'b1;
      d.value = diff[NibbleWidth-1:0] + DigitTen;
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      diff    = c - ChUpperA;
      d.ok    = 1'b1;
      d.value = diff[NibbleWidth-1:0] + DigitTen;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

/* sv/hdwa_if.sv */
// ----------------------------------------------------------------------------
// hdwa_if
// Valid/ready channels of the hex-dump word assembler: one for text
// characters, one for assembled words.
// ----------------------------------------------------------------------------
interface hdwa_ch_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface hdwa_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

/* sv/hdwa_parser.sv */
// ----------------------------------------------------------------------------
// hdwa_parser
// Line/byte state machine plus word accumulator. Consumes one character
// whenever step is high and reports a finished word in the same cycle.
// ----------------------------------------------------------------------------
module hdwa_parser
  import hdwa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [CharWidth-1:0] ch,
  output parse_result_t        result
);

  typedef enum logic [5:0] {
    LINE_START = 6'b000001,
    SKIP       = 6'b000010,
    BETWEEN    = 6'b000100,
    HIGH       = 6'b001000,
    LOW        = 6'b010000,
    HALT       = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [NibbleWidth-1:0] high_nibble, high_nibble_next;
  logic [WordWidth-1:0]   word_accum, word_accum_next;
  logic [1:0]             byte_count, byte_count_next;
  hex_digit_t             digit;

  assign digit = hex_decode(ch);

  // next state for the current character
  always_comb begin
    phase_next       = phase;
    high_nibble_next = high_nibble;
    word_accum_next  = word_accum;
    byte_count_next  = byte_count;
    result.emit      = 1'b0;
    result.word      = {word_accum[WordWidth-ByteWidth-1:0], high_nibble, digit.value};
    unique case (phase)
      LINE_START: begin
        if (ch != ChNewline) phase_next = SKIP;
      end
      SKIP: begin
        if (ch == ChSpace) phase_next = HIGH;
      end
      BETWEEN: begin
        priority if (ch == ChNewline) phase_next = LINE_START;
        else if (ch == ChSpace) phase_next = HIGH;
        else phase_next = BETWEEN;
      end
      HIGH: begin
        if (digit.ok) begin
          high_nibble_next = digit.value;
          phase_next       = LOW;
        end else begin
          phase_next = HALT;
        end
      end
      LOW: begin
        if (digit.ok) begin
          word_accum_next = result.word;
          byte_count_next = byte_count + 2'd1;
          result.emit     = (byte_count == LastByte);
          phase_next      = BETWEEN;
        end else begin
          phase_next = HALT;
        end
      end
      default: phase_next = HALT;
    endcase
  end

  // state registers advance only on a consumed character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= LINE_START;
      high_nibble <= '0;
      word_accum  <= '0;
      byte_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      word_accum  <= word_accum_next;
      byte_count  <= byte_count_next;
    end
  end

endmodule

/* sv/hex_dump_word_assembler.sv */
// ----------------------------------------------------------------------------
// hex_dump_word_assembler
// Packs the bytes of a hex-dump listing into 32-bit big-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   chars : one ASCII character per item (valid/ready, field ch).
//   words : one assembled 32-bit word per item (valid/ready, field word),
//           first byte of the word in bits 31..24.
//   Each line's offset prefix (first character, then up to the next space)
//   is skipped; each following space starts a two-digit hex byte. Every
//   fourth byte, counted across lines, yields one word. A bad digit stops
//   the parser until reset.
//   Path: a character is captured in the input register and parsed from
//   there; a word it completes is held in the result register and offered
//   on words from there.
//   Throughput: one character per cycle while no word waits on words; the
//   state update of the parser sets it.
//   Reset (rst, synchronous): parser returns to line start, byte count and
//   accumulator clear, both pipeline registers empty.
//   Stall: while a word waits on words, the input register holds its
//   character and chars deasserts ready once that register is occupied.
// ----------------------------------------------------------------------------
module hex_dump_word_assembler
  import hdwa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  hdwa_ch_if.sink          chars,
  hdwa_word_if.source      words
);

  logic                 in_valid;
  logic [CharWidth-1:0] in_ch;
  logic                 out_valid;
  logic [WordWidth-1:0] out_word;
  logic                 advance;
  logic                 step;
  parse_result_t        result;

  // the parse stage moves when the result register is free or draining
  assign advance     = !out_valid || words.ready;
  assign step        = in_valid && advance;
  assign chars.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_ch <= chars.ch;
    end
  end

  hdwa_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .ch     (in_ch),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.emit) begin
      out_word <= result.word;
    end
  end

  assign words.valid = out_valid;
  assign words.word  = out_word;

endmodule

/* verif/hex_dump_word_assembler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_dump_word_assembler_checker
// Watches the character and word channels of the hex-dump word assembler.
// Every character taken in feeds a local copy of the line parser; the words
// that parser completes are queued and compared in order against the words
// the block hands out.
// ----------------------------------------------------------------------------
module hex_dump_word_assembler_checker
  import hdwa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  hdwa_ch_if    chars,
  hdwa_word_if  words,
  output int    mismatches,
  output int    outstanding
);

  typedef enum logic [2:0] {
    PhLineStart = 3'd0,
    PhSkip      = 3'd1,
    PhBetween   = 3'd2,
    PhHigh      = 3'd3,
    PhLow       = 3'd4,
    PhHalt      = 3'd5
  } parse_phase_t;

  // local parser state
  parse_phase_t             phase;
  logic [NibbleWidth-1:0]   hi_digit;
  logic [WordWidth-1:0]     acc;
  logic [1:0]               byte_cnt;
  logic [WordWidth-1:0]     word_q[$];

  // {is_digit, value}
  function automatic logic [NibbleWidth:0] digit_of(input logic [CharWidth-1:0] c);
    if (c >= ChZero && c <= ChNine) begin
      return {1'b1, 4'(c - ChZero)};
    end
    if (c >= ChLowerA && c <= ChLowerF) begin
      return {1'b1, 4'(c - ChLowerA) + 4'd10};
    end
    if (c >= ChUpperA && c <= ChUpperF) begin
      return {1'b1, 4'(c - ChUpperA) + 4'd10};
    end
    return '0;
  endfunction

  // advance the parser by one character, queue a completed word
  task automatic parse_char(input logic [CharWidth-1:0] c);
    logic [NibbleWidth:0] d;
    d = digit_of(c);
    case (phase)
      PhLineStart: begin
        if (c != ChNewline) phase = PhSkip;
      end
      PhSkip: begin
        if (c == ChSpace) phase = PhHigh;
      end
      PhBetween: begin
        if (c == ChNewline) phase = PhLineStart;
        else if (c == ChSpace) phase = PhHigh;
      end
      PhHigh: begin
        if (d[NibbleWidth]) begin
          hi_digit = d[NibbleWidth-1:0];
          phase    = PhLow;
        end else begin
          phase = PhHalt;
        end
      end
      PhLow: begin
        if (d[NibbleWidth]) begin
          acc      = {acc[WordWidth-ByteWidth-1:0], hi_digit, d[NibbleWidth-1:0]};
          byte_cnt = byte_cnt + 2'd1;
          if (byte_cnt == 2'd0) word_q.push_back(acc);
          phase = PhBetween;
        end else begin
          phase = PhHalt;
        end
      end
      default: phase = PhHalt;  // halted for good
    endcase
  endtask

  always @(posedge clk) begin
    logic [WordWidth-1:0] exp_word;
    if (rst) begin
      phase      = PhLineStart;
      hi_digit   = '0;
      acc        = '0;
      byte_cnt   = '0;
      word_q.delete();
      mismatches = 0;
    end else begin
      if (chars.valid && chars.ready) parse_char(chars.ch);
      // compare each word handed out against the oldest prediction
      if (words.valid && words.ready) begin
        if (word_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: expected none, actual %h", $time, words.word);
        end else begin
          exp_word = word_q.pop_front();
          if (words.word !== exp_word) begin
            mismatches++;
            $display("%0t: word mismatch: expected %h, actual %h",
                     $time, exp_word, words.word);
          end
        end
      end
    end
    outstanding <= word_q.size();
  end

endmodule

/* verif/hex_dump_word_assembler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_dump_word_assembler_tb
// Feeds hex-dump text to the word assembler: a directed listing with the
// corner cases of the line format, then random lines with junk, newlines in
// the prefix and empty lines, and finally a bad digit that halts the parser.
// Both channels idle at random; the word side also holds off for long
// stretches. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module hex_dump_word_assembler_tb;
  import hdwa_pkg::*;

  localparam int CycleLimit   = 500000;
  localparam int DirectedLen  = 26;
  localparam int RandomItems  = 1750;
  localparam int PauseAt      = 900;
  localparam int SettleCycles = 10;
  localparam int HoldLen      = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   chars_sent = 0;
  bit   tx_burst = 1'b0;
  bit   prev_had_bytes = 1'b0;
  int   fail_count;
  int   words_pending;

  hdwa_ch_if   char_ch ();
  hdwa_word_if word_ch ();

  hex_dump_word_assembler u_top (
    .clk   (clk),
    .rst   (rst),
    .chars (char_ch),
    .words (word_ch)
  );

  hex_dump_word_assembler_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .chars       (char_ch),
    .words       (word_ch),
    .mismatches  (fail_count),
    .outstanding (words_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("hex_dump_word_assembler_tb failed");
      $finish;
    end
  end

  // digit character for nib, either case at random for a..f
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return ChZero + 8'(nib);
    return (($urandom_range(0, 1) != 0) ? ChUpperA : ChLowerA) + 8'(nib - 4'd10);
  endfunction

  // any character that neither starts a byte nor ends a line
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChSpace || c == ChNewline);
    return c;
  endfunction

  // offer one item and hold it until taken
  task automatic send_char(input logic [7:0] c);
    int gap;
    int r;
    gap = 0;
    if (!tx_burst) begin
      r = $urandom_range(0, 99);
      if (r >= 97)      gap = $urandom_range(20, 60);
      else if (r >= 88) gap = $urandom_range(3, 8);
      else if (r >= 60) gap = $urandom_range(1, 2);
    end
    repeat (gap) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.ch    <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // sender stops until every predicted word has come out
  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    do @(posedge clk);
    while (words_pending != 0);
  endtask

  // one listing line: first char, prefix, bytes with optional junk, newline
  task automatic send_line();
    int n_body;
    int n_bytes;
    tx_burst = ($urandom_range(0, 9) < 3);
    if ($urandom_range(0, 7) == 0) send_char(ChNewline);
    // a leading space is safe only when the parser really sits at line start
    if (prev_had_bytes && $urandom_range(0, 5) == 0) send_char(ChSpace);
    else send_char(junk_char());
    n_body = $urandom_range(0, 8);
    repeat (n_body) begin
      if ($urandom_range(0, 9) == 0) send_char(ChNewline);
      else send_char(junk_char());
    end
    n_bytes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
    repeat (n_bytes) begin
      if ($urandom_range(0, 7) == 0) send_char(junk_char());
      send_char(ChSpace);
      send_char(hex_char(4'($urandom_range(0, 15))));
      send_char(hex_char(4'($urandom_range(0, 15))));
    end
    if ($urandom_range(0, 3) == 0) send_char(junk_char());
    send_char(ChNewline);
    prev_had_bytes = (n_bytes != 0);
  endtask

  // word side: random ready in changing modes, two long hold-offs
  initial begin
    int cyc;
    int hold;
    int mode;
    cyc  = 0;
    hold = 0;
    mode = 0;
    word_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc == 700 || cyc == 3000) hold = HoldLen;
      if (hold > 0) begin
        hold--;
        word_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: word_ch.ready <= 1'b1;
          1: word_ch.ready <= ($urandom_range(0, 9) < 7);
          2: word_ch.ready <= ($urandom_range(0, 9) < 3);
          default: word_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // character side and verdict
  initial begin
    bit paused;
    logic [7:0] bad;
    paused = 1'b0;
    char_ch.valid <= 1'b0;
    char_ch.ch    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // newline and space as first char, newline and extremes in the prefix,
    // digits of both cases, junk between bytes, word across a line break
    send_char(ChNewline);
    send_char(ChSpace);
    send_char(8'h00);
    send_char(ChNewline);
    send_char(8'hFF);
    send_text(" 00z Ff 9a AF\n\n7 10");
    send_char(8'h80);
    send_char(ChNewline);
    wait_drained();

    while (chars_sent < DirectedLen + RandomItems) begin
      send_line();
      if (!paused && chars_sent > DirectedLen + PauseAt) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    // bad digit on the high or low nibble; the parser then stays halted
    tx_burst = 1'b0;
    send_text("0 ");
    if ($urandom_range(0, 1) != 0) send_char(hex_char(4'($urandom_range(0, 15))));
    case ($urandom_range(0, 3))
      0: bad = ChNewline;
      1: bad = ChSpace;
      2: bad = 8'($urandom_range(8'h67, 8'hFF));
      default: bad = 8'($urandom_range(8'h00, 8'h2F));
    endcase
    send_char(bad);
    send_text(" 12 34 56 78 9A bc de F0\n0 11 22 33 44\n");
    wait_drained();
    repeat (SettleCycles) @(posedge clk);

    if (fail_count == 0 && words_pending == 0) begin
      $display("hex_dump_word_assembler_tb passed");
    end else begin
      $display("hex_dump_word_assembler_tb failed");
    end
    $finish;
  end

endmodule
